FILE: hdl/camera_output_sequencer_macros.svh
//------------------------------------------------------------------------------
// Camera output sequencer assertion macros
// Shared assertion forms for the sequencer's modules. Each use needs clk and
// rst in scope.
//------------------------------------------------------------------------------
`ifndef CAMERA_OUTPUT_SEQUENCER_MACROS_SVH
`define CAMERA_OUTPUT_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("camera_output_sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define COS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("camera_output_sequencer: next-cycle check failed");

`endif

FILE: hdl/cos_pkg.sv
//------------------------------------------------------------------------------
// Camera output sequencer package
// Sizes, codes, controller states and the command and status bundles shared
// by the controller and the datapath.
//------------------------------------------------------------------------------
package cos_pkg;

  // Sizes of the camera list and the activity queue.
  localparam int MAX_CAMERAS = 16;
  localparam int QUEUE_DEPTH = 8;

  localparam int LIST_AW   = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int ENTRY_AW  = 4;
  localparam int QUEUE_AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W    = FILL_W + 1;

  // Field widths.
  localparam int ID_W       = 32;
  localparam int SUB_W      = 16;
  localparam int COUNT_W    = 5;
  localparam int DWELL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WORDS      = 4;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_CLIENT = 2'd1,
    REQ_EVENT  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_CLIENT = 2'd0,
    MODE_SEQ    = 2'd1,
    MODE_ACT    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_DWELL   = 3'd1,
    CFG_COUNT   = 3'd2,
    CFG_WORDS_A = 3'd3,
    CFG_WORDS_B = 3'd4,
    CFG_WORDS_C = 3'd5,
    CFG_WORDS_D = 3'd6,
    CFG_GROUP   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LIST_SCAN,
    ST_CLIENT_EMIT,
    ST_SEQ_EMIT,
    ST_ACT_EMIT,
    ST_Q_READ,
    ST_Q_CMP,
    ST_Q_INSERT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic cnt_dec;
    logic scan_inc;
    logic list_seq;
    logic client_emit;
    logic seq_emit;
    logic act_read;
    logic act_emit;
    logic q_read;
    logic q_inc;
    logic q_write;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] mode;
    logic       halted;
    logic       cnt_zero;
    logic       list_empty;
    logic       list_hit;
    logic       scan_last;
    logic       queue_empty;
    logic       queue_full;
    logic       q_match;
    logic       q_last;
    logic       out_free;
  } status_t;

  // Queue slot at base plus offset, modulo the queue depth. The offset never
  // exceeds the depth, so one compare and subtract is enough.
  function automatic logic [QUEUE_AW-1:0] q_wrap(input logic [QUEUE_AW-1:0] base,
                                                 input logic [FILL_W-1:0] offset);
    logic [QSUM_W-1:0] sum;
    sum = QSUM_W'(base) + QSUM_W'(offset);
    if (sum >= QSUM_W'(QUEUE_DEPTH)) begin
      sum = sum - QSUM_W'(QUEUE_DEPTH);
    end
    return QUEUE_AW'(sum);
  endfunction

endpackage

FILE: hdl/cos_if.sv
//------------------------------------------------------------------------------
// Camera output sequencer channels
// Valid/ready channels for incoming requests and outgoing camera switches.
//------------------------------------------------------------------------------
interface cos_req_if import cos_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [ID_W-1:0]  camera_id;

  modport source (output valid, output req_type, output camera_id, input ready);
  modport sink   (input valid, input req_type, input camera_id, output ready);
endinterface

interface cos_sel_if import cos_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  switch_id;
  logic             stopped;

  modport source (output valid, output switch_id, output stopped, input ready);
  modport sink   (input valid, input switch_id, input stopped, output ready);
endinterface

FILE: hdl/cos_ctrl.sv
//------------------------------------------------------------------------------
// Camera output sequencer controller
// State machine that walks one request through dispatch, list search, queue
// search and result hand-off, driving the datapath by commands.
//------------------------------------------------------------------------------
module cos_ctrl import cos_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_e state;
  state_e state_next;

  logic is_tick;
  logic is_client;
  logic is_event;
  logic tick_seq;
  logic tick_act;
  logic tick_wait;

  // Request decode shared by the next-state and command blocks below.
  always_comb begin
    is_tick   = (status.req_type == REQ_TICK);
    is_client = (status.req_type == REQ_CLIENT);
    is_event  = (status.req_type == REQ_EVENT);
    tick_seq  = is_tick && !status.halted && (status.mode == MODE_SEQ);
    tick_act  = is_tick && !status.halted && (status.mode == MODE_ACT);
    tick_wait = (tick_seq || tick_act) && !status.cnt_zero;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_next = ST_IDLE;
        if (tick_seq && status.cnt_zero && !status.list_empty) begin
          state_next = ST_SEQ_EMIT;
        end else if (tick_act && status.cnt_zero && !status.queue_empty) begin
          state_next = ST_ACT_EMIT;
        end else if (is_client && status.mode == MODE_CLIENT && !status.list_empty) begin
          state_next = ST_LIST_SCAN;
        end else if (is_event && status.mode == MODE_ACT && !status.list_empty) begin
          state_next = ST_LIST_SCAN;
        end
      end
      ST_LIST_SCAN: begin
        if (status.list_hit) begin
          if (is_client) begin
            state_next = ST_CLIENT_EMIT;
          end else if (status.queue_full) begin
            state_next = ST_IDLE;
          end else if (status.queue_empty) begin
            state_next = ST_Q_INSERT;
          end else begin
            state_next = ST_Q_READ;
          end
        end else if (status.scan_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLIENT_EMIT, ST_SEQ_EMIT, ST_ACT_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_Q_READ: begin
        state_next = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        if (status.q_match) begin
          state_next = ST_IDLE;
        end else if (status.q_last) begin
          state_next = ST_Q_INSERT;
        end else begin
          state_next = ST_Q_READ;
        end
      end
      ST_Q_INSERT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_item = req_valid;
      end
      ST_DISPATCH: begin
        cmd.cnt_dec  = tick_wait;
        cmd.act_read = tick_act && status.cnt_zero && !status.queue_empty;
      end
      ST_LIST_SCAN: begin
        cmd.scan_inc = !status.list_hit && !status.scan_last;
      end
      ST_CLIENT_EMIT: begin
        cmd.client_emit = status.out_free;
      end
      ST_SEQ_EMIT: begin
        cmd.list_seq = 1'b1;
        cmd.seq_emit = status.out_free;
      end
      ST_ACT_EMIT: begin
        cmd.act_emit = status.out_free;
      end
      ST_Q_READ: begin
        cmd.q_read = 1'b1;
      end
      ST_Q_CMP: begin
        cmd.q_inc = !status.q_match && !status.q_last;
      end
      ST_Q_INSERT: begin
        cmd.q_write = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/cos_datapath.sv
//------------------------------------------------------------------------------
// Camera output sequencer datapath
// Configuration registers, camera list lookup, sequencer and dwell state,
// activity queue memory and the result register.
//------------------------------------------------------------------------------
`include "camera_output_sequencer_macros.svh"

module cos_datapath import cos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            item_type,
  input  logic [ID_W-1:0]       item_id,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  sel_valid,
  input  logic                  sel_ready,
  output logic [ID_W-1:0]       sel_switch_id,
  output logic                  sel_stopped
);

  // Configuration.
  logic [1:0]            mode;
  logic [DWELL_W-1:0]    dwell_time;
  logic [COUNT_W-1:0]    camera_count;
  logic [CFG_DATA_W-1:0] camera_words [WORDS];
  logic [SUB_W-1:0]      source_group;

  // Working state.
  logic [1:0]            req_type;
  logic [ID_W-1:0]       req_id;
  logic [LIST_AW-1:0]    scan_idx;
  logic [COUNT_W-1:0]    seq_index;
  logic [DWELL_W-1:0]    countdown;
  logic                  halted;
  logic [QUEUE_AW-1:0]   queue_head;
  logic [FILL_W-1:0]     queue_fill;
  logic [FILL_W-1:0]     q_idx;
  logic [ID_W-1:0]       queue_mem [QUEUE_DEPTH];
  logic [ID_W-1:0]       queue_rdata;

  logic [COUNT_W-1:0]    list_n;
  logic [LIST_AW-1:0]    seq_addr;
  logic [LIST_AW-1:0]    list_addr;
  logic [ENTRY_AW-1:0]   entry_addr;
  logic [SUB_W-1:0]      list_entry;
  logic [QUEUE_AW-1:0]   q_rd_addr;
  logic [QUEUE_AW-1:0]   q_wr_addr;
  logic                  seq_stop;
  logic                  emit_any;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= '0;
      dwell_time   <= '0;
      camera_count <= '0;
      source_group <= '0;
      for (int w = 0; w < WORDS; w++) camera_words[w] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode            <= cfg_wdata[1:0];
        CFG_DWELL:   dwell_time      <= cfg_wdata[DWELL_W-1:0];
        CFG_COUNT:   camera_count    <= cfg_wdata[COUNT_W-1:0];
        CFG_WORDS_A: camera_words[0] <= cfg_wdata;
        CFG_WORDS_B: camera_words[1] <= cfg_wdata;
        CFG_WORDS_C: camera_words[2] <= cfg_wdata;
        CFG_WORDS_D: camera_words[3] <= cfg_wdata;
        CFG_GROUP:   source_group    <= cfg_wdata[SUB_W-1:0];
        default:     mode            <= mode;
      endcase
    end
  end

  // List length, clamped to the list capacity, and the single list read port.
  // The sequencer index wraps to the first entry once it runs past the end.
  always_comb begin
    list_n     = (camera_count > COUNT_W'(MAX_CAMERAS)) ? COUNT_W'(MAX_CAMERAS)
                                                        : camera_count;
    seq_addr   = (seq_index >= list_n) ? '0 : LIST_AW'(seq_index);
    list_addr  = cmd.list_seq ? seq_addr : scan_idx;
    entry_addr = ENTRY_AW'(list_addr);
    list_entry = camera_words[entry_addr[3:2]][entry_addr[1:0]*SUB_W +: SUB_W];
    seq_stop   = (dwell_time != '0) && (list_n == COUNT_W'(1));
    q_rd_addr  = cmd.act_read ? queue_head : q_wrap(queue_head, q_idx);
    q_wr_addr  = q_wrap(queue_head, queue_fill);
    emit_any   = cmd.client_emit || cmd.seq_emit || cmd.act_emit;
  end

  // Latched request and walk counters.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_type <= item_type;
      req_id   <= item_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      q_idx    <= '0;
    end else begin
      if (cmd.load_item) begin
        scan_idx <= '0;
        q_idx    <= '0;
      end else begin
        if (cmd.scan_inc) scan_idx <= scan_idx + LIST_AW'(1);
        if (cmd.q_inc)    q_idx    <= q_idx + FILL_W'(1);
      end
    end
  end

  // Sequencer and dwell state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_index <= '0;
      countdown <= '0;
      halted    <= 1'b0;
    end else begin
      if (cmd.cnt_dec) begin
        countdown <= countdown - DWELL_W'(1);
      end
      if (cmd.seq_emit) begin
        seq_index <= COUNT_W'(seq_addr) + COUNT_W'(1);
        if (dwell_time != '0) begin
          countdown <= dwell_time - DWELL_W'(1);
          if (list_n == COUNT_W'(1)) halted <= 1'b1;
        end
      end
      if (cmd.act_emit) begin
        countdown <= dwell_time;
      end
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head <= '0;
      queue_fill <= '0;
    end else if (cmd.act_emit) begin
      queue_head <= q_wrap(queue_head, FILL_W'(1));
      queue_fill <= queue_fill - FILL_W'(1);
    end else if (cmd.q_write) begin
      queue_fill <= queue_fill + FILL_W'(1);
    end
  end

  // Queue memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.q_write) begin
      queue_mem[q_wr_addr] <= req_id;
    end
    if (cmd.q_read || cmd.act_read) begin
      queue_rdata <= queue_mem[q_rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (emit_any) begin
      sel_valid <= 1'b1;
    end else if (sel_ready) begin
      sel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.client_emit) begin
      sel_switch_id <= req_id;
      sel_stopped   <= 1'b0;
    end else if (cmd.seq_emit) begin
      sel_switch_id <= {source_group, list_entry};
      sel_stopped   <= seq_stop;
    end else if (cmd.act_emit) begin
      sel_switch_id <= queue_rdata;
      sel_stopped   <= 1'b0;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.req_type    = req_type;
    status.mode        = mode;
    status.halted      = halted;
    status.cnt_zero    = (countdown == '0);
    status.list_empty  = (list_n == '0);
    status.list_hit    = (list_entry == req_id[SUB_W-1:0]);
    status.scan_last   = (COUNT_W'(scan_idx) + COUNT_W'(1) >= list_n);
    status.queue_empty = (queue_fill == '0);
    status.queue_full  = (queue_fill == FILL_W'(QUEUE_DEPTH));
    status.q_match     = (queue_rdata == req_id);
    status.q_last      = (q_idx + FILL_W'(1) == queue_fill);
    status.out_free    = !sel_valid || sel_ready;
  end

  // The fill count never passes the queue depth.
  `COS_ASSERT_SAME(a_fill_bound, 1'b1, queue_fill <= FILL_W'(QUEUE_DEPTH))
  // A halt is reported by the result loaded in the same cycle.
  `COS_ASSERT_SAME(a_halt_reported, $rose(halted), sel_valid && sel_stopped)
  // A result is only loaded when the result register is free.
  `COS_ASSERT_SAME(a_emit_free, emit_any, status.out_free)
  // An insert grows the queue by exactly one entry.
  `COS_ASSERT_NEXT(a_fill_step, cmd.q_write, queue_fill == $past(queue_fill) + FILL_W'(1))

endmodule

FILE: hdl/camera_output_sequencer.sv
//------------------------------------------------------------------------------
// Camera output sequencer
// Picks the camera a video output shows in client, sequencer or activity mode.
//------------------------------------------------------------------------------
// The block takes one request at a time. A tick or an ignored request is
// accepted and then dispatched; a tick that switches then loads the result.
// A client request or activity event walks the camera list one entry per
// cycle through a single list read port, and a client hit then loads the
// result. An activity event that passes then searches the queue for a
// duplicate through the queue memory's one read port, reading and then
// comparing each queued id, and inserts the id if none matches. A full queue
// drops the event at once, so the search covers at most seven ids with the
// default sizes. A result sits in an output register, so the next request is
// accepted while it waits; a result-producing request holds only if the
// previous result has still not been taken.
module camera_output_sequencer import cos_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cos_req_if.sink               request,
  cos_sel_if.source             selection
);

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  // Request channel ready comes from the controller.
  assign request.ready = req_ready;

  cos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cos_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .item_type     (request.req_type),
    .item_id       (request.camera_id),
    .cmd           (cmd),
    .status        (status),
    .sel_valid     (selection.valid),
    .sel_ready     (selection.ready),
    .sel_switch_id (selection.switch_id),
    .sel_stopped   (selection.stopped)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Camera output sequencer testbench
// Drives client requests, sequencer ticks and activity events through the
// request channel. A cycle-free model of the block predicts every camera
// switch. Each accepted switch is checked in order against the oldest
// prediction. The sender works in bursts and the receiver stalls on a
// pattern of its own, so that gaps fall on every part of the block's work.
//------------------------------------------------------------------------------
module tb_top;
  import cos_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int ITEM_GOAL    = 1600;

  typedef struct packed {
    logic [ID_W-1:0] switch_id;
    logic            stopped;
  } switch_t;

  // Tracks the block's configuration and state and works out the switch
  // that each accepted request causes.
  class camera_choice;
    mode_e              mode;
    logic [DWELL_W-1:0] dwell;
    logic [COUNT_W-1:0] count;
    logic [63:0]        words[WORDS];
    logic [SUB_W-1:0]   group;
    logic [4:0]         seq_index;
    logic [DWELL_W-1:0] countdown;
    bit                 halted;
    logic [ID_W-1:0]    queue[QUEUE_DEPTH];
    int                 head;
    int                 fill;
    switch_t            due_switches[$];
    int                 errors;

    function new();
      mode      = MODE_CLIENT;
      dwell     = '0;
      count     = '0;
      group     = '0;
      seq_index = '0;
      countdown = '0;
      halted    = 1'b0;
      head      = 0;
      fill      = 0;
      errors    = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:    mode  = mode_e'(val[1:0]);
        CFG_DWELL:   dwell = val[DWELL_W-1:0];
        CFG_COUNT:   count = val[COUNT_W-1:0];
        CFG_WORDS_A: words[0] = val;
        CFG_WORDS_B: words[1] = val;
        CFG_WORDS_C: words[2] = val;
        CFG_WORDS_D: words[3] = val;
        CFG_GROUP:   group = val[SUB_W-1:0];
        default: ;
      endcase
    endfunction

    // Counts beyond the list size act as the full list.
    function int list_len();
      return (count > MAX_CAMERAS) ? MAX_CAMERAS : int'(count);
    endfunction

    function logic [SUB_W-1:0] entry(int i);
      return words[i / 4][(i % 4) * 16 +: 16];
    endfunction

    function bit in_list(logic [SUB_W-1:0] sub);
      for (int i = 0; i < list_len(); i++) begin
        if (entry(i) == sub) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push_switch(logic [ID_W-1:0] id, logic stop);
      switch_t s;
      s.switch_id = id;
      s.stopped   = stop;
      due_switches.push_back(s);
    endfunction

    // Sequencer: count down, then step through the list and show the next camera.
    function void seq_tick();
      int n;
      logic [SUB_W-1:0] sub;
      logic stop;
      if (countdown != 0) begin
        countdown = countdown - 1'b1;
        return;
      end
      n = list_len();
      if (n == 0) return;
      if (seq_index >= n) seq_index = '0;
      sub = entry(seq_index);
      seq_index = seq_index + 1'b1;
      stop = 1'b0;
      if (dwell != 0) begin
        countdown = dwell - 1'b1;
        if (n == 1) begin
          halted = 1'b1;
          stop = 1'b1;
        end
      end
      push_switch({group, sub}, stop);
    endfunction

    // Activity: each expired dwell period shows the oldest queued camera.
    function void act_tick();
      if (countdown != 0) begin
        countdown = countdown - 1'b1;
        return;
      end
      if (fill == 0) return;
      push_switch(queue[head], 1'b0);
      head = (head + 1) % QUEUE_DEPTH;
      fill--;
      countdown = dwell;
    endfunction

    // Listed cameras are queued once; a full queue drops new ones.
    function void act_event(logic [ID_W-1:0] id);
      if (!in_list(id[SUB_W-1:0])) return;
      for (int i = 0; i < fill; i++) begin
        if (queue[(head + i) % QUEUE_DEPTH] == id) return;
      end
      if (fill >= QUEUE_DEPTH) return;
      queue[(head + fill) % QUEUE_DEPTH] = id;
      fill++;
    endfunction

    function void note_request(req_type_e kind, logic [ID_W-1:0] id);
      case (kind)
        REQ_TICK: begin
          if (!halted) begin
            if (mode == MODE_SEQ) seq_tick();
            else if (mode == MODE_ACT) act_tick();
          end
        end
        REQ_CLIENT: begin
          if (mode == MODE_CLIENT && in_list(id[SUB_W-1:0])) push_switch(id, 1'b0);
        end
        REQ_EVENT: begin
          if (mode == MODE_ACT) act_event(id);
        end
        default: ;
      endcase
    endfunction

    function void check_switch(logic [ID_W-1:0] id, logic stop);
      switch_t want;
      if (due_switches.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected switch: got %h stopped %b", id, stop);
        return;
      end
      want = due_switches.pop_front();
      if (want.switch_id !== id || want.stopped !== stop) begin
        errors++;
        if (errors <= 10) begin
          $display("switch mismatch: expected %h stopped %b, got %h stopped %b",
                   want.switch_id, want.stopped, id, stop);
        end
      end
    endfunction

    function int pending();
      return due_switches.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cos_req_if req_ch ();
  cos_sel_if sel_ch ();

  camera_output_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .request   (req_ch),
    .selection (sel_ch)
  );

  camera_choice chooser = new();

  // Stimulus view of the current setup.
  mode_e            cur_mode;
  logic [SUB_W-1:0] cam_list[MAX_CAMERAS];
  int               cam_len;
  logic [SUB_W-1:0] grp_a;
  logic [SUB_W-1:0] grp_b;
  int               burst_left = 0;
  int               useful_items = 0;
  int               idle_cycles = 0;
  int               seg_left = 0;
  int               seg_style = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: segments of always ready, random stalls, rare ready and
  // periodic long stalls.
  always @(negedge clk) begin
    if (seg_left == 0) begin
      seg_style = $urandom_range(0, 3);
      seg_left = $urandom_range(8, 96);
    end else begin
      seg_left = seg_left - 1;
    end
    case (seg_style)
      0: sel_ch.ready <= 1'b1;
      1: sel_ch.ready <= 1'($urandom_range(0, 1));
      2: sel_ch.ready <= ($urandom_range(0, 5) == 0);
      default: sel_ch.ready <= ((seg_left % 12) < 3);
    endcase
  end

  // Monitor: note accepted requests and check accepted switches.
  always @(posedge clk) begin
    if (!rst) begin
      if (sel_ch.valid && sel_ch.ready) chooser.check_switch(sel_ch.switch_id, sel_ch.stopped);
      if (req_ch.valid && req_ch.ready) begin
        chooser.note_request(req_type_e'(req_ch.req_type), req_ch.camera_id);
      end
      if ((sel_ch.valid && sel_ch.ready) || (req_ch.valid && req_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    @(posedge clk);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Offers one request and waits for it to be taken; bursts end in a gap.
  task automatic send_item(req_type_e kind, logic [ID_W-1:0] id);
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.camera_id <= id;
    @(posedge clk);
    while (!(req_ch.valid && req_ch.ready)) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 20);
    end
  endtask

  // Stops sending until every predicted switch has come out.
  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (chooser.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    chooser.set_reg(idx, val);
  endtask

  // Writes every register once the block has gone quiet.
  task automatic apply_setup(mode_e m, logic [DWELL_W-1:0] d, logic [COUNT_W-1:0] c,
                             logic [WORDS-1:0][CFG_DATA_W-1:0] w, logic [SUB_W-1:0] g);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_DWELL, CFG_DATA_W'(d));
    write_reg(CFG_COUNT, CFG_DATA_W'(c));
    write_reg(CFG_WORDS_A, w[0]);
    write_reg(CFG_WORDS_B, w[1]);
    write_reg(CFG_WORDS_C, w[2]);
    write_reg(CFG_WORDS_D, w[3]);
    write_reg(CFG_GROUP, CFG_DATA_W'(g));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_mode = m;
    cam_len = (c > MAX_CAMERAS) ? MAX_CAMERAS : int'(c);
    for (int i = 0; i < MAX_CAMERAS; i++) cam_list[i] = w[i / 4][(i % 4) * 16 +: 16];
  endtask

  // Mostly listed sub-ids, sometimes any value.
  function automatic logic [ID_W-1:0] make_id(logic [SUB_W-1:0] grp);
    logic [ID_W-1:0] r;
    r = $urandom;
    if (cam_len > 0 && $urandom_range(0, 99) < 85) r[SUB_W-1:0] = cam_list[$urandom_range(0, cam_len - 1)];
    return {grp, r[SUB_W-1:0]};
  endfunction

  task automatic random_setup();
    mode_e m;
    logic [DWELL_W-1:0] d;
    logic [COUNT_W-1:0] c;
    logic [WORDS-1:0][CFG_DATA_W-1:0] w;
    logic [SUB_W-1:0] e;
    int k;
    m = mode_e'($urandom_range(0, 2));
    k = $urandom_range(0, 9);
    d = (k < 4) ? '0 : (k < 9) ? DWELL_W'($urandom_range(1, 4)) : DWELL_W'($urandom_range(5, 20));
    k = $urandom_range(0, 19);
    c = (k == 0) ? '0 : (k == 1) ? COUNT_W'(16) :
        (k == 2) ? COUNT_W'($urandom_range(17, 31)) : COUNT_W'($urandom_range(1, 16));
    // A one-camera sequence with a dwell time would halt for good.
    if (m == MODE_SEQ && (c == 1) && d != 0) d = '0;
    for (int i = 0; i < MAX_CAMERAS; i++) begin
      case ($urandom_range(0, 7))
        0: e = '0;
        1: e = '1;
        2: e = SUB_W'($urandom_range(0, 3));
        default: e = SUB_W'($urandom);
      endcase
      w[i / 4][(i % 4) * 16 +: 16] = e;
    end
    k = $urandom_range(0, 19);
    if (k == 0) w[$urandom_range(0, 3)] = '1;
    else if (k == 1) w[$urandom_range(0, 3)] = '0;
    grp_a = SUB_W'($urandom);
    grp_b = SUB_W'($urandom);
    apply_setup(m, d, c, w, SUB_W'($urandom));
  endtask

  task automatic random_phase(int items);
    int k;
    logic [SUB_W-1:0] g;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      if (k == 0) hold_until_drained();
      useful_items++;
      case (cur_mode)
        MODE_CLIENT: begin
          if (k < 75) begin
            send_item(REQ_CLIENT, make_id(SUB_W'($urandom)));
          end else if (k < 88) begin
            send_item(REQ_TICK, $urandom);
          end else begin
            send_item(REQ_EVENT, make_id(grp_a));
          end
        end
        MODE_SEQ: begin
          if (k < 85) begin
            send_item(REQ_TICK, $urandom);
          end else if (k < 93) begin
            send_item(REQ_CLIENT, make_id(SUB_W'($urandom)));
          end else begin
            send_item(REQ_EVENT, make_id(grp_a));
          end
        end
        default: begin
          if (k < 50) begin
            case ($urandom_range(0, 3))
              0, 1: g = grp_a;
              2: g = grp_b;
              default: g = SUB_W'($urandom);
            endcase
            send_item(REQ_EVENT, make_id(g));
          end else if (k < 95) begin
            send_item(REQ_TICK, $urandom);
          end else begin
            send_item(REQ_CLIENT, make_id(SUB_W'($urandom)));
          end
        end
      endcase
    end
  endtask

  // Main sequence.
  initial begin
    logic [WORDS-1:0][CFG_DATA_W-1:0] dir_words;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MODE;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_TICK;
    req_ch.camera_id = '0;
    sel_ch.ready     = 1'b0;
    cur_mode         = MODE_CLIENT;
    cam_len          = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir_words = {64'h000C_000B_000A_0009, 64'h0008_0007_0006_0005,
                 64'h0004_0003_0002_0001, 64'hABCD_1234_FFFF_0000};

    // Client mode with an oversized count: extreme ids, a miss, wrong-mode items.
    apply_setup(MODE_CLIENT, '0, 5'd31, dir_words, 16'hFFFF);
    send_item(REQ_CLIENT, 32'hFFFF_0000);
    send_item(REQ_CLIENT, 32'h0000_FFFF);
    send_item(REQ_CLIENT, 32'hFFFF_FFFF);
    send_item(REQ_CLIENT, 32'h1234_5555);
    send_item(REQ_TICK, 32'hFFFF_FFFF);
    send_item(REQ_EVENT, 32'h0000_1234);

    // Sequencer with zero dwell: switches on every tick and wraps the list.
    apply_setup(MODE_SEQ, '0, 5'd3, dir_words, 16'hFFFF);
    repeat (4) send_item(REQ_TICK, 32'h0);
    send_item(REQ_CLIENT, 32'h0000_0000);

    // Empty list: switch points emit nothing.
    apply_setup(MODE_SEQ, '0, 5'd0, dir_words, 16'h0000);
    repeat (2) send_item(REQ_TICK, 32'h0);

    // Shorter list than the current index: the sequence restarts at entry zero.
    apply_setup(MODE_SEQ, '0, 5'd1, dir_words, 16'h0000);
    repeat (2) send_item(REQ_TICK, 32'h0);

    // Activity queue: duplicate and unlisted events, dwell countdown.
    apply_setup(MODE_ACT, 16'd1, 5'd2, dir_words, 16'h0000);
    send_item(REQ_EVENT, 32'h0000_0000);
    send_item(REQ_EVENT, 32'h0000_0000);
    send_item(REQ_EVENT, 32'hFFFF_FFFF);
    send_item(REQ_EVENT, 32'h0000_FFFF);
    send_item(REQ_EVENT, 32'h1234_0001);
    repeat (3) send_item(REQ_TICK, 32'h0);

    // Random phases.
    while (useful_items < ITEM_GOAL) begin
      random_setup();
      random_phase($urandom_range(20, 120));
    end

    // One camera with the longest dwell: the sequencer stops for good.
    apply_setup(MODE_SEQ, 16'hFFFF, 5'd1, dir_words, SUB_W'($urandom));
    while (!chooser.halted) send_item(REQ_TICK, $urandom);
    repeat (3) send_item(REQ_TICK, $urandom);

    // After the stop, requests and events still work but ticks do not.
    apply_setup(MODE_CLIENT, 16'd0, 5'd2, dir_words, 16'h0000);
    repeat (4) send_item(REQ_CLIENT, make_id(SUB_W'($urandom)));
    apply_setup(MODE_ACT, 16'd0, 5'd2, dir_words, 16'h0000);
    repeat (3) send_item(REQ_EVENT, make_id(SUB_W'($urandom)));
    repeat (3) send_item(REQ_TICK, $urandom);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chooser.errors == 0 && chooser.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
